// File: hdl/assert_macros.svh
// Assertion macros shared by the console RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: hdl/tcs_pkg.sv
// Types, constants and helpers for the text console scrollback unit.
// Used by every module of the block; depends on nothing.
package tcs_pkg;

  localparam int TEXT_COLS   = 79;
  localparam int VIEW_ROWS   = 25;
  localparam int SCREEN_COLS = 80;
  localparam int STORE_ROWS  = 256;
  localparam int BAR_COLUMN  = 79;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BAR      = 8'h7C;
  localparam logic [7:0] COLOR_RESET = 8'h0F;

  localparam logic [3:0] MODE_PUTC    = 4'd0;
  localparam logic [3:0] MODE_PUT     = 4'd1;
  localparam logic [3:0] MODE_SETCUR  = 4'd2;
  localparam logic [3:0] MODE_UP      = 4'd3;
  localparam logic [3:0] MODE_DOWN    = 4'd4;
  localparam logic [3:0] MODE_FOLLOW  = 4'd5;
  localparam logic [3:0] MODE_CLEAR   = 4'd6;
  localparam logic [3:0] MODE_CLRROW  = 4'd7;
  localparam logic [3:0] MODE_SHOW    = 4'd8;
  localparam logic [3:0] MODE_READ    = 4'd9;

  localparam logic REG_COLOR = 1'b0;

  typedef enum logic [3:0] {
    OP_PUTC, OP_NEWLINE, OP_PUT, OP_SETCUR, OP_UP, OP_DOWN,
    OP_FOLLOW, OP_CLEAR, OP_CLRROW, OP_SHOW, OP_READ, OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_EXEC, BK_RDWAIT, BK_DIV, BK_WAIT, BK_DONE
  } back_st_e;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] ch;
    logic [7:0] row;
    logic [6:0] col;
  } in_t;

  typedef struct packed {
    logic [4:0]  cursor_view_row;
    logic [6:0]  cursor_col;
    logic [7:0]  cursor_buffer_row;
    logic [7:0]  view_top_row;
    logic        following;
    logic [4:0]  bar_pos_row;
    logic [10:0] hw_cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        accepted;
  } out_t;

  // One classified command between front and back
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [7:0] row;
    logic [6:0] col;
    logic       ok;
  } cmd_t;

  // Top row that puts the given row on the bottom window row
  function automatic logic [7:0] row_tail(logic [7:0] r);
    logic [7:0] res;
    res = (r >= 8'(VIEW_ROWS - 1)) ? r - 8'(VIEW_ROWS - 1) : 8'd0;
    return res;
  endfunction

endpackage

// File: hdl/tcs_front.sv
// Front end: takes input beats and classifies them into commands.
// Depends on tcs_pkg.
module tcs_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcs_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output tcs_pkg::cmd_t q_cmd_o
);
  import tcs_pkg::*;

  // Stall while the command queue is full
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Decode the mode and clamp or range-check the position fields
  always_comb begin
    q_cmd_o.op  = OP_NOP;
    q_cmd_o.ch  = in_data_i.ch;
    q_cmd_o.row = in_data_i.row;
    q_cmd_o.col = in_data_i.col;
    q_cmd_o.ok  = 1'b1;
    unique case (in_data_i.mode)
      MODE_PUTC: begin
        q_cmd_o.op = (in_data_i.ch == CH_NEWLINE) ? OP_NEWLINE : OP_PUTC;
      end
      MODE_PUT: begin
        q_cmd_o.op = OP_PUT;
        q_cmd_o.ok = (in_data_i.row < 8'(VIEW_ROWS)) && (in_data_i.col < 7'(TEXT_COLS));
      end
      MODE_SETCUR: begin
        q_cmd_o.op = OP_SETCUR;
        if (in_data_i.row >= 8'(VIEW_ROWS)) q_cmd_o.row = 8'(VIEW_ROWS - 1);
        if (in_data_i.col >= 7'(TEXT_COLS)) q_cmd_o.col = 7'(TEXT_COLS - 1);
      end
      MODE_UP:     q_cmd_o.op = OP_UP;
      MODE_DOWN:   q_cmd_o.op = OP_DOWN;
      MODE_FOLLOW: q_cmd_o.op = OP_FOLLOW;
      MODE_CLEAR:  q_cmd_o.op = OP_CLEAR;
      MODE_CLRROW: begin
        q_cmd_o.op = OP_CLRROW;
        q_cmd_o.ok = in_data_i.row < 8'(VIEW_ROWS);
      end
      MODE_SHOW:   q_cmd_o.op = OP_SHOW;
      MODE_READ: begin
        q_cmd_o.op = OP_READ;
        if (in_data_i.row >= 8'(VIEW_ROWS)) q_cmd_o.row = 8'(VIEW_ROWS - 1);
        if (in_data_i.col >= 7'(SCREEN_COLS)) q_cmd_o.col = 7'(SCREEN_COLS - 1);
      end
      default:     q_cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/tcs_cmdq.sv
// Short command queue that decouples the front end from the back end.
// Depends on tcs_pkg.
module tcs_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcs_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tcs_pkg::cmd_t cmd_o
);
  import tcs_pkg::*;

  localparam int PtrW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  cmd_t            slot_q [CMDQ_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(CMDQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = slot_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

endmodule

// File: hdl/tcs_mdiv.sv
// Scrollbar marker divider: top*VIEW_ROWS/(max_top+1), one quotient bit a cycle.
// Depends on tcs_pkg.
module tcs_mdiv (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] top_i,
  input  logic [7:0] newest_i,
  output logic       done_o,
  output logic [4:0] marker_o
);
  import tcs_pkg::*;

  logic        busy_q;
  logic [2:0]  step_q;
  logic [13:0] rem_q;
  logic [8:0]  den_q;
  logic [4:0]  quo_q;

  logic [7:0]  max_top;
  logic [13:0] num;
  logic [8:0]  den;
  logic [13:0] sat_lim;
  logic [2:0]  bit_idx;
  logic [13:0] trial;

  assign max_top = row_tail(newest_i);
  assign num     = 14'(top_i) * 14'(VIEW_ROWS);
  assign den     = 9'(max_top) + 9'd1;
  assign sat_lim = 14'(den) * 14'(VIEW_ROWS - 1);
  assign bit_idx = step_q - 3'd1;
  assign trial   = 14'(den_q) << bit_idx;

  assign done_o   = busy_q && (step_q == 3'd0);
  assign marker_o = quo_q;

  // Restoring division; a zero max top gives zero and a quotient of VIEW_ROWS-1 or more saturates at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      rem_q  <= num;
      den_q  <= den;
      if (max_top == 8'd0) begin
        quo_q  <= '0;
        step_q <= 3'd0;
      end else if (num >= sat_lim) begin
        quo_q  <= 5'(VIEW_ROWS - 1);
        step_q <= 3'd0;
      end else begin
        quo_q  <= '0;
        step_q <= 3'd5;
      end
    end else if (busy_q) begin
      if (step_q == 3'd0) begin
        busy_q <= 1'b0;
      end else begin
        if (rem_q >= trial) begin
          rem_q          <= rem_q - trial;
          quo_q[bit_idx] <= 1'b1;
        end
        step_q <= step_q - 3'd1;
      end
    end
  end

endmodule

// File: hdl/tcs_back.sv
// Back end: executes console commands against the row store and cursor state,
// computes the marker and holds the result beat. Depends on tcs_pkg, tcs_mdiv.
`include "assert_macros.svh"
module tcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tcs_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  input  logic [7:0]    color_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcs_pkg::out_t out_data_o
);
  import tcs_pkg::*;

  typedef logic [TEXT_COLS-1:0][7:0] row_t;

  back_st_e st_q, st_d;
  cmd_t     cmd_q;

  logic [7:0] ring_q, ring_d, cur_row_q, cur_row_d, top_q, top_d, newest_q, newest_d;
  logic [6:0] cur_col_q, cur_col_d;
  logic       follow_q, follow_d;
  logic [4:0] marker_q, marker_d, vr_q;
  logic [7:0] rc_q, rc_d;
  logic       acc_q, acc_d;

  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  // Row store with one valid bit per physical row; invalid rows read as spaces
  row_t       store_q [STORE_ROWS];
  logic       row_valid_q [STORE_ROWS];
  row_t       rdata_q;
  logic       rvalid_q;
  logic [7:0] rd_addr, wr_addr_q;
  logic       mem_we;
  row_t       row_cur, row_new;
  logic       set_en, clr_en, clr_all;
  logic [7:0] clr_idx;

  logic [8:0] sum_a;
  logic       a_in;
  logic [7:0] tail;
  logic [8:0] top_plus;
  logic [6:0] col_inc;
  logic       wrap;
  logic [7:0] top_tmp;
  logic [7:0] row_nx;
  logic [4:0] vr;
  logic [6:0] vc;
  logic       div_start, div_done;
  logic [4:0] div_q;

  assign sum_a    = 9'(top_q) + 9'(cmd_q.row);
  assign a_in     = sum_a < 9'(STORE_ROWS);
  assign tail     = row_tail(newest_q);
  assign top_plus = 9'(top_q) + 9'(VIEW_ROWS);
  assign col_inc  = cur_col_q + 7'd1;
  assign wrap     = (cmd_q.op == OP_NEWLINE) || (col_inc >= 7'(TEXT_COLS));
  assign row_cur  = rvalid_q ? rdata_q : {TEXT_COLS{CH_SPACE}};

  // Physical row address; STORE_ROWS is a power of two so the ring wraps freely
  always_comb begin
    case (cmd_q.op) inside
      OP_PUTC, OP_NEWLINE: rd_addr = cur_row_q + ring_q;
      default:             rd_addr = sum_a[7:0] + ring_q;
    endcase
  end

  // Merge the new bytes into the row read from the store
  always_comb begin
    for (int c = 0; c < TEXT_COLS; c++) begin
      row_new[c] = row_cur[c];
      if (cmd_q.op == OP_NEWLINE && 7'(c) >= cur_col_q) row_new[c] = CH_SPACE;
      if (cmd_q.op == OP_PUTC && 7'(c) == cur_col_q)    row_new[c] = cmd_q.ch;
      if (cmd_q.op == OP_PUT && 7'(c) == cmd_q.col)     row_new[c] = cmd_q.ch;
    end
  end

  // Cursor position seen in the window
  always_comb begin
    if (cur_row_q < top_q) vr = '0;
    else if ((cur_row_q - top_q) >= 8'(VIEW_ROWS)) vr = 5'(VIEW_ROWS - 1);
    else vr = 5'(cur_row_q - top_q);
    vc = cur_col_q;
    if (vc >= 7'(TEXT_COLS)) vc = 7'(TEXT_COLS - 1);
    if (vc >= 7'(SCREEN_COLS)) vc = 7'(SCREEN_COLS - 1);
  end

  // Next state and command execution
  always_comb begin
    st_d        = st_q;
    ring_d      = ring_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    top_d       = top_q;
    newest_d    = newest_q;
    follow_d    = follow_q;
    marker_d    = marker_q;
    rc_d        = rc_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_all     = 1'b0;
    clr_idx     = '0;
    div_start   = 1'b0;
    top_tmp     = top_q;
    row_nx      = cur_row_q + 8'd1;

    // Drop the result once it is taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (st_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          st_d    = BK_EXEC;
        end
      end

      BK_EXEC: begin
        rc_d  = '0;
        acc_d = 1'b1;
        st_d  = BK_DIV;
        case (cmd_q.op) inside
          OP_PUTC, OP_NEWLINE: st_d = BK_RDWAIT;
          OP_PUT: begin
            acc_d = cmd_q.ok && a_in;
            if (cmd_q.ok && a_in) st_d = BK_RDWAIT;
          end
          OP_SETCUR: begin
            cur_row_d = a_in ? sum_a[7:0] : 8'(STORE_ROWS - 1);
            cur_col_d = cmd_q.col;
          end
          OP_UP: begin
            if (top_q != 8'd0) top_d = top_q - 8'd1;
            follow_d = 1'b0;
          end
          OP_DOWN: begin
            if (top_q < tail) top_d = top_q + 8'd1;
            if (top_d == tail) follow_d = 1'b1;
          end
          OP_FOLLOW: begin
            top_d    = tail;
            follow_d = 1'b1;
          end
          OP_CLEAR: begin
            clr_all   = 1'b1;
            ring_d    = '0;
            cur_row_d = '0;
            cur_col_d = '0;
            top_d     = '0;
            newest_d  = '0;
            follow_d  = 1'b1;
          end
          OP_CLRROW: begin
            acc_d = cmd_q.ok && a_in;
            if (cmd_q.ok && a_in) begin
              clr_en  = 1'b1;
              clr_idx = rd_addr;
            end
          end
          OP_SHOW: begin
            if (cmd_q.row < top_q) top_d = cmd_q.row;
            else if (9'(cmd_q.row) >= top_plus) top_d = cmd_q.row - 8'(VIEW_ROWS - 1);
          end
          OP_READ: begin
            rc_d = CH_SPACE;
            if (cmd_q.col == 7'(BAR_COLUMN)) begin
              if (cmd_q.row == 8'(marker_q)) rc_d = CH_BAR;
            end else if (cmd_q.col < 7'(TEXT_COLS) && a_in) begin
              st_d = BK_RDWAIT;
            end
          end
          default: ;
        endcase
      end

      BK_RDWAIT: begin
        st_d = BK_DIV;
        if (cmd_q.op == OP_READ) begin
          rc_d = row_cur[cmd_q.col];
        end else begin
          mem_we = 1'b1;
          set_en = 1'b1;
        end
        if (cmd_q.op == OP_PUTC || cmd_q.op == OP_NEWLINE) begin
          if (wrap) begin
            // End the line: move on and blank the next row
            cur_col_d = '0;
            clr_en    = 1'b1;
            if (cur_row_q != 8'(STORE_ROWS - 1)) begin
              cur_row_d = row_nx;
              clr_idx   = row_nx + ring_q;
            end else begin
              ring_d    = ring_q + 8'd1;
              cur_row_d = 8'(STORE_ROWS - 1);
              clr_idx   = ring_q;
              if (top_q != 8'd0) top_tmp = top_q - 8'd1;
            end
          end else begin
            cur_col_d = col_inc;
          end
          newest_d = cur_row_d;
          top_d    = follow_q ? row_tail(cur_row_d) : top_tmp;
        end
      end

      BK_DIV: begin
        div_start = 1'b1;
        st_d      = BK_WAIT;
      end

      BK_WAIT: begin
        if (div_done) begin
          marker_d = div_q;
          st_d     = BK_DONE;
        end
      end

      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d               = 1'b1;
          out_d.cursor_view_row     = vr_q;
          out_d.cursor_col          = cur_col_q;
          out_d.cursor_buffer_row   = cur_row_q;
          out_d.view_top_row        = top_q;
          out_d.following           = follow_q;
          out_d.bar_pos_row         = marker_q;
          out_d.hw_cursor_pos       = 11'(vr_q) * 11'(SCREEN_COLS) + 11'(vc);
          out_d.read_char           = rc_q;
          out_d.read_attr           = (cmd_q.op == OP_READ) ? color_i : 8'd0;
          out_d.accepted            = acc_q;
          st_d                      = BK_IDLE;
        end
      end

      default: st_d = BK_IDLE;
    endcase
  end

  // Control and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      ring_q      <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      newest_q    <= '0;
      follow_q    <= 1'b1;
      marker_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ring_q      <= ring_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      newest_q    <= newest_d;
      follow_q    <= follow_d;
      marker_q    <= marker_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    rc_q  <= rc_d;
    acc_q <= acc_d;
    out_q <= out_d;
    if (st_q == BK_DIV) vr_q <= vr;
    if (st_q == BK_EXEC) wr_addr_q <= rd_addr;
  end

  // Row valid bits; a cleared row reads as spaces
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < STORE_ROWS; r++) row_valid_q[r] <= 1'b0;
    end else if (clr_all) begin
      for (int r = 0; r < STORE_ROWS; r++) row_valid_q[r] <= 1'b0;
    end else begin
      if (set_en) row_valid_q[wr_addr_q] <= 1'b1;
      if (clr_en) row_valid_q[clr_idx] <= 1'b0;
    end
  end

  // Row store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[wr_addr_q] <= row_new;
    rdata_q  <= store_q[rd_addr];
    rvalid_q <= row_valid_q[rd_addr];
  end

  tcs_mdiv u_mdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .top_i    (top_q),
    .newest_i (newest_q),
    .done_o   (div_done),
    .marker_o (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_marker_range, clk_i, rst_ni, marker_q < 5'(VIEW_ROWS), "marker out of window")
  `ASSERT_ALWAYS(a_col_range, clk_i, rst_ni, cur_col_q < 7'(TEXT_COLS), "cursor column past text")
  `ASSERT_ALWAYS(a_div_wait, clk_i, rst_ni, !div_done || st_q == BK_WAIT, "stray divider done")
  `ASSERT_NEXT(a_clear_home, clk_i, rst_ni, st_q == BK_EXEC && cmd_q.op == OP_CLEAR, cur_row_q == 8'd0 && top_q == 8'd0 && follow_q, "clear left cursor away from home")

endmodule

// File: hdl/text_console_scrollback_unit.sv
// Top level of the text console scrollback unit: APB colour register,
// front end, command queue and back end. Depends on tcs_pkg and all tcs_ modules.
//
//   port group | direction | beat
//   in_*       | in        | in_t: mode, ch, row, col
//   out_*      | out       | out_t: cursor, view, marker, read cell, accepted
//   APB        | in/out    | colour register at byte address 0
//
// An item passes the back end in order: queue pop, execute, a row read for
// text, put and read (written back for text and put), a divider start, the
// marker divider (no division steps when the newest row fits the window or the
// marker saturates) and the result load. The store keeps one valid bit per row,
// so reset and clear take effect at once with no clearing pass. The queue takes
// beats until full while the back end works or the result waits on out_stall_i.
module text_console_scrollback_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcs_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tcs_pkg::*;

  logic [7:0] color_q;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       push_cmd, head_cmd;

  // Colour register write and read back
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_COLOR) begin
      color_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == REG_COLOR) ? {24'd0, color_q} : 32'd0;

  tcs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  tcs_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  tcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .color_i     (color_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: dv/tb.sv
// Testbench for text_console_scrollback_unit: random and directed console
// commands checked against a scoreboard that mirrors the console state.
// Depends on tcs_pkg and the RTL of the unit.
module tb;
  import tcs_pkg::*;

  // Console state mirror and store of pending results
  class console_board;
    logic [7:0] cells [STORE_ROWS*TEXT_COLS];
    int unsigned ring, crow, ccol, vtop, newest, follow, attr;
    out_t pending [$];
    int errors;

    function void wipe();
      foreach (cells[i]) cells[i] = CH_SPACE;
      ring = 0; crow = 0; ccol = 0; vtop = 0; newest = 0; follow = 1;
    endfunction

    function int unsigned idx(int unsigned r, int unsigned c);
      return ((r % STORE_ROWS + ring) % STORE_ROWS) * TEXT_COLS + (c % TEXT_COLS);
    endfunction

    function void blank(int unsigned r);
      if (r >= STORE_ROWS) return;
      for (int c = 0; c < TEXT_COLS; c++) cells[idx(r, c)] = CH_SPACE;
    endfunction

    function int unsigned tail_top();
      return newest >= VIEW_ROWS ? newest - VIEW_ROWS + 1 : 0;
    endfunction

    function void track();
      if (follow) vtop = crow >= VIEW_ROWS - 1 ? crow - (VIEW_ROWS - 1) : 0;
    endfunction

    function void end_line();
      while (ccol < TEXT_COLS) begin
        cells[idx(crow, ccol)] = CH_SPACE;
        ccol++;
      end
      ccol = 0;
      if (crow + 1 < STORE_ROWS) begin
        crow++;
      end else begin
        ring = (ring + 1) % STORE_ROWS;
        crow = STORE_ROWS - 1;
        if (vtop > 0) vtop--;
      end
      blank(crow);
      track();
      newest = crow;
    endfunction

    function int unsigned marker();
      int unsigned mt, m;
      mt = tail_top();
      m = 0;
      if (mt > 0) m = (vtop * VIEW_ROWS) / (mt + 1);
      if (m >= VIEW_ROWS) m = VIEW_ROWS - 1;
      return m;
    endfunction

    // Note an accepted command and queue the result it must produce
    function void note_command(in_t it);
      int unsigned r, c, a, rc, ra, acc, vr, vc;
      out_t o;
      r = it.row; c = it.col; acc = 1; rc = 0; ra = 0;
      case (it.mode)
        MODE_PUTC: begin
          if (it.ch == CH_NEWLINE) end_line();
          else begin
            if (ccol >= TEXT_COLS) end_line();
            cells[idx(crow, ccol)] = it.ch;
            ccol++;
            if (ccol >= TEXT_COLS) end_line();
            else begin
              newest = crow;
              track();
            end
          end
        end
        MODE_PUT: begin
          a = vtop + r;
          if (r >= VIEW_ROWS || c >= TEXT_COLS || a >= STORE_ROWS) acc = 0;
          else cells[idx(a, c)] = it.ch;
        end
        MODE_SETCUR: begin
          if (r >= VIEW_ROWS) r = VIEW_ROWS - 1;
          if (c >= TEXT_COLS) c = TEXT_COLS - 1;
          crow = vtop + r;
          if (crow >= STORE_ROWS) crow = STORE_ROWS - 1;
          ccol = c;
        end
        MODE_UP: begin
          if (vtop > 0) vtop--;
          follow = 0;
        end
        MODE_DOWN: begin
          a = tail_top();
          if (vtop < a) vtop++;
          if (vtop == a) follow = 1;
        end
        MODE_FOLLOW: begin
          vtop = tail_top();
          follow = 1;
        end
        MODE_CLEAR: wipe();
        MODE_CLRROW: begin
          a = vtop + r;
          if (r >= VIEW_ROWS || a >= STORE_ROWS) acc = 0;
          else blank(a);
        end
        MODE_SHOW: begin
          if (r >= STORE_ROWS) r = STORE_ROWS - 1;
          if (r < vtop) vtop = r;
          else if (r >= vtop + VIEW_ROWS) vtop = r - (VIEW_ROWS - 1);
        end
        MODE_READ: begin
          if (r >= VIEW_ROWS) r = VIEW_ROWS - 1;
          if (c >= SCREEN_COLS) c = SCREEN_COLS - 1;
          a = vtop + r;
          rc = CH_SPACE;
          if (c == BAR_COLUMN) begin
            if (r == marker()) rc = CH_BAR;
          end else if (c < TEXT_COLS && a < STORE_ROWS) begin
            rc = cells[idx(a, c)];
          end
          ra = attr;
        end
        default: ;
      endcase
      vr = crow >= vtop ? crow - vtop : 0;
      if (vr >= VIEW_ROWS) vr = VIEW_ROWS - 1;
      vc = ccol;
      if (vc >= TEXT_COLS) vc = TEXT_COLS - 1;
      if (vc >= SCREEN_COLS) vc = SCREEN_COLS - 1;
      o.cursor_view_row   = 5'(vr);
      o.cursor_col        = 7'(ccol);
      o.cursor_buffer_row = 8'(crow);
      o.view_top_row      = 8'(vtop);
      o.following         = 1'(follow);
      o.bar_pos_row       = 5'(marker());
      o.hw_cursor_pos     = 11'(vr * SCREEN_COLS + vc);
      o.read_char         = 8'(rc);
      o.read_attr         = 8'(ra);
      o.accepted          = 1'(acc);
      pending.push_back(o);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // Compare a result beat against the oldest pending expectation
    task check_result(out_t g);
      out_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (g.cursor_view_row !== e.cursor_view_row)
        report("cursor_view_row", g.cursor_view_row, e.cursor_view_row);
      if (g.cursor_col !== e.cursor_col) report("cursor_col", g.cursor_col, e.cursor_col);
      if (g.cursor_buffer_row !== e.cursor_buffer_row)
        report("cursor_buffer_row", g.cursor_buffer_row, e.cursor_buffer_row);
      if (g.view_top_row !== e.view_top_row)
        report("view_top_row", g.view_top_row, e.view_top_row);
      if (g.following !== e.following) report("following", g.following, e.following);
      if (g.bar_pos_row !== e.bar_pos_row)
        report("bar_pos_row", g.bar_pos_row, e.bar_pos_row);
      if (g.hw_cursor_pos !== e.hw_cursor_pos)
        report("hw_cursor_pos", g.hw_cursor_pos, e.hw_cursor_pos);
      if (g.read_char !== e.read_char) report("read_char", g.read_char, e.read_char);
      if (g.read_attr !== e.read_attr) report("read_attr", g.read_attr, e.read_attr);
      if (g.accepted !== e.accepted) report("accepted", g.accepted, e.accepted);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  console_board board;
  int unsigned cycles;
  bit steady;          // no idling on either side
  bit drain_hold;      // receiver holds off for a long stretch

  text_console_scrollback_unit i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Count cycles and stop the run at a generous limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side at random, or hold off entirely on request
  always @(posedge clk_i) begin
    if (drain_hold) out_stall_i <= 1'b1;
    else if (steady) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 35);
  end

  // Check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // Drive one command beat and wait for its acceptance; valid stays high after
  task automatic send_beat(in_t it);
    if (!steady && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!steady && $urandom_range(99) < 35) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(it);
  endtask

  task automatic send(logic [3:0] m, logic [7:0] c, logic [7:0] r, logic [6:0] k);
    in_t it;
    it.mode = m; it.ch = c; it.row = r; it.col = k;
    send_beat(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write the colour register through the APB port while idle
  task automatic write_colour(logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_COLOR); pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.attr = v;
  endtask

  // Random command, weighted towards text output
  task automatic random_beat();
    in_t it;
    int unsigned p;
    it = in_t'(27'($urandom));
    p = $urandom_range(99);
    if (p < 45) begin
      it.mode = MODE_PUTC;
      if ($urandom_range(9) == 0) it.ch = CH_NEWLINE;
    end else if (p < 88) begin
      it.mode = 4'($urandom_range(MODE_READ, MODE_PUT));
      if (it.mode == MODE_CLEAR && $urandom_range(5) != 0) it.mode = MODE_READ;
      if ($urandom_range(2) != 0) it.row = 8'($urandom_range(VIEW_ROWS + 1));
      if ($urandom_range(2) != 0) it.col = 7'($urandom_range(SCREEN_COLS));
    end else if (p < 97) begin
      it.mode = MODE_READ;
      it.col = 7'(BAR_COLUMN);
      it.row = 8'($urandom_range(VIEW_ROWS - 1));
    end else begin
      it.mode = 4'($urandom_range(15, 10));
    end
    send_beat(it);
  endtask

  initial begin
    board = new();
    board.wipe();
    board.attr = COLOR_RESET;
    board.errors = 0;
    cycles = 0;
    steady = 0; drain_hold = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, each mode, clamps and rejections
    send(MODE_READ, 8'h00, 8'd0, 7'd0);
    send(MODE_PUTC, 8'hFF, 8'd0, 7'd0);
    send(MODE_PUTC, 8'h00, 8'd0, 7'd0);
    send(MODE_PUTC, CH_NEWLINE, 8'd0, 7'd0);
    send(MODE_PUT, 8'h41, 8'd0, 7'd5);
    send(MODE_PUT, 8'h41, 8'd25, 7'd5);
    send(MODE_PUT, 8'h41, 8'd0, 7'd79);
    send(MODE_SETCUR, 8'h00, 8'hFF, 7'h7F);
    send(MODE_PUTC, 8'h42, 8'd0, 7'd0);
    send(MODE_READ, 8'h00, 8'hFF, 7'h7F);
    send(MODE_READ, 8'h00, 8'd0, 7'd79);
    send(MODE_UP, 8'h00, 8'd0, 7'd0);
    send(MODE_DOWN, 8'h00, 8'd0, 7'd0);
    send(MODE_FOLLOW, 8'h00, 8'd0, 7'd0);
    send(MODE_CLRROW, 8'h00, 8'd1, 7'd0);
    send(MODE_CLRROW, 8'h00, 8'd200, 7'd0);
    send(MODE_SHOW, 8'h00, 8'hFF, 7'd0);
    send(MODE_SHOW, 8'h00, 8'd0, 7'd0);
    send(MODE_READ, 8'h00, 8'd0, 7'd1);
    send(4'hF, 8'hFF, 8'hFF, 7'h7F);
    send(MODE_CLEAR, 8'h00, 8'd0, 7'd0);
    drain();
    write_colour(8'hFF);

    // Long text run: one full line that wraps, then enough lines to scroll the ring
    steady = 1;
    for (int i = 0; i < 400; i++)
      send(MODE_PUTC, (i >= 100 && i % 7 != 0) ? CH_NEWLINE : 8'($urandom_range(126, 32)),
           8'd0, 7'd0);
    steady = 0;
    drain();
    write_colour(8'h00);

    // Receiver holds off while the sender keeps offering beats
    drain_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        drain_hold = 0;
      end
      for (int i = 0; i < 40; i++) random_beat();
    join
    drain();
    write_colour(8'h5A);

    for (int i = 0; i < 1200; i++) begin
      random_beat();
      if (i == 600) begin
        drain();
        write_colour(8'($urandom));
      end
    end
    drain();

    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
